// ===== design/assert_macros.svh =====
// Assertion helpers for the I2C sequencer.
// Both sample on clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/i2cseq_pkg.sv =====
package i2cseq_pkg;

	localparam int BUF_DEPTH = 16;
	localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CNT_W     = 5;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [1:0] {
		CMD_POLL  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_WRITE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_READ  = 2'd1,
		PEND_WRITE = 2'd2
	} pend_t;

	typedef enum logic [2:0] {
		STAT_IDLE    = 3'd0,
		STAT_READING = 3'd1,
		STAT_RDONE   = 3'd2,
		STAT_WRITING = 3'd3,
		STAT_WDONE   = 3'd4
	} stat_t;

	localparam logic [7:0] RD_BIT = 8'h01;

	// One result beat, before the buffer byte is merged in.
	typedef struct packed {
		logic       do_start;
		logic       do_restart;
		logic       do_stop;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_prime;
		logic       send_nack;
		logic       clear_flag;
		stat_t      status;
		logic       rd_valid;
		logic [3:0] rd_index;
		logic [7:0] rd_byte;
	} res_t;

endpackage

// ===== design/i2cseq_ram.sv =====
module i2cseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/i2c_register_transaction_sequencer.sv =====
// I2C register transaction sequencer.
// Input stream (s_*): one beat per item. s_tuser carries the command: poll step,
// load a write-buffer byte, post a read request or post a write request. s_tdata
// carries the addresses, byte count, buffer slot/byte and the controller's
// done flag and receive byte.
// Output stream (m_*): exactly one result beat per input beat, in order: the bus
// command for the byte-level controller (start, restart, stop, transmit byte,
// receive prime with ack/nack, flag clear), the status after the item and any
// received data byte.
// Pipeline: taking an input beat updates the sequencer state, issues the
// write-buffer read and registers the result in the middle stage; moving it on
// merges the buffer byte into the output register.
// Throughput: one beat per cycle. The write buffer is a 16-entry RAM with one
// write port (load beats) and one registered read port (data bytes of a write).
// A load is visible to the very next poll, so no forwarding is needed.
// Stall: when m_tready is low the output register holds; one more item may
// enter the middle stage, after which s_tready drops until m_tready returns.
// Reset (arst_n low): sequencer idle, no request pending, status idle, both
// pipeline stages empty. Buffer contents are not cleared.
`include "assert_macros.svh"

module i2c_register_transaction_sequencer
	import i2cseq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// low to high: dev_addr[7:0], reg_addr[15:8], byte_count[20:16],
	// buf_index[24:21], write_byte[32:25], bus_done[33], rx_byte[41:34], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// low to high: do_start[0], do_restart[1], do_stop[2], tx_valid[3],
	// tx_byte[11:4], rx_prime[12], send_nack[13], clear_flag[14], status[17:15],
	// rd_valid[18], rd_index[22:19], rd_byte[30:23], zero pad[31]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_RDEV   = 4'd1,
		ST_RREG   = 4'd2,
		ST_WAIT   = 4'd3,
		ST_RST    = 4'd4,
		ST_REC    = 4'd5,
		ST_STOP   = 4'd6,
		ST_RDDONE = 4'd7,
		ST_WDEV   = 4'd8,
		ST_WREG   = 4'd9,
		ST_WDATA  = 4'd10
	} seq_t;

	// input fields
	cmd_t             in_cmd;
	logic [7:0]       in_dev;
	logic [7:0]       in_reg;
	logic [CNT_W-1:0] in_cnt;
	logic [3:0]       in_idx;
	logic [7:0]       in_wbyte;
	logic             in_done;
	logic [7:0]       in_rx;

	assign in_cmd   = cmd_t'(s_tuser[1:0]);
	assign in_dev   = s_tdata[7:0];
	assign in_reg   = s_tdata[15:8];
	assign in_cnt   = s_tdata[20:16];
	assign in_idx   = s_tdata[24:21];
	assign in_wbyte = s_tdata[32:25];
	assign in_done  = s_tdata[33];
	assign in_rx    = s_tdata[41:34];

	// sequencer state
	seq_t             state_q, state_d;
	seq_t             resume_q, resume_d;
	pend_t            pend_q, pend_d;
	logic [7:0]       taddr_q, taddr_d;
	logic [7:0]       raddr_q, raddr_d;
	logic [CNT_W-1:0] tlen_q, tlen_d;
	logic [CNT_W-1:0] rcnt_q, rcnt_d;
	logic [CNT_W-1:0] wcnt_q, wcnt_d;
	logic             last_q, last_d;
	stat_t            bstat_q, bstat_d;

	res_t res_d;
	logic mem_sel_d;

	// pipeline
	logic       accept;
	logic       adv2;
	logic       s1_valid_q;
	res_t       res_s1;
	logic       mem_sel_s1;
	res_t       res_merge;
	logic       s2_valid_q;
	res_t       res_s2;
	logic [7:0] buf_rdata;

	assign adv2     = s1_valid_q && (!s2_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv2;
	assign accept   = s_tvalid && s_tready;

	// write buffer: loads write; every taken beat reads at the write byte counter for the data phase
	i2cseq_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH),
		.AW    (BUF_AW)
	) u_buf (
		.clk   (clk),
		.we    (accept && in_cmd == CMD_LOAD && int'(in_idx) < BUF_DEPTH),
		.waddr (BUF_AW'(in_idx)),
		.wdata (in_wbyte),
		.re    (accept),
		.raddr (wcnt_q[BUF_AW-1:0]),
		.rdata (buf_rdata)
	);

	// next state and bus command for one item
	always_comb begin
		state_d   = state_q;
		resume_d  = resume_q;
		pend_d    = pend_q;
		taddr_d   = taddr_q;
		raddr_d   = raddr_q;
		tlen_d    = tlen_q;
		rcnt_d    = rcnt_q;
		wcnt_d    = wcnt_q;
		last_d    = last_q;
		bstat_d   = bstat_q;
		res_d     = '0;
		mem_sel_d = 1'b0;

		case (in_cmd)
			CMD_POLL: begin
				case (state_q)
					ST_IDLE: begin
						if (pend_q == PEND_READ) begin
							state_d = ST_RDEV;
						end else if (pend_q == PEND_WRITE) begin
							state_d = ST_WDEV;
						end
					end
					ST_RDEV: begin
						if (pend_q == PEND_READ) begin
							bstat_d          = STAT_READING;
							res_d.do_start   = 1'b1;
							res_d.tx_valid   = 1'b1;
							res_d.tx_byte    = taddr_q;
							state_d          = ST_WAIT;
							resume_d         = ST_RREG;
						end
					end
					ST_WAIT: begin
						if (in_done) begin
							res_d.clear_flag = 1'b1;
							state_d          = resume_q;
						end
					end
					ST_RREG: begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = raddr_q;
						state_d        = ST_WAIT;
						resume_d       = ST_RST;
					end
					ST_RST: begin
						res_d.do_restart = 1'b1;
						res_d.tx_valid   = 1'b1;
						res_d.tx_byte    = taddr_q | RD_BIT;
						state_d          = ST_WAIT;
						resume_d         = ST_REC;
					end
					ST_REC: begin
						if (rcnt_q < tlen_q) begin
							last_d          = (rcnt_q + CNT_W'(1)) == tlen_q;
							res_d.rx_prime  = 1'b1;
							res_d.send_nack = last_d;
							state_d         = ST_WAIT;
							resume_d        = ST_STOP;
						end else begin
							state_d = ST_RDDONE;
							rcnt_d  = '0;
						end
					end
					ST_STOP: begin
						res_d.do_stop  = last_q;
						res_d.rd_valid = 1'b1;
						res_d.rd_index = rcnt_q[3:0];
						res_d.rd_byte  = in_rx;
						rcnt_d         = rcnt_q + CNT_W'(1);
						state_d        = ST_REC;
						resume_d       = ST_STOP;
					end
					ST_RDDONE: begin
						bstat_d = STAT_RDONE;
						pend_d  = PEND_NONE;
						state_d = ST_IDLE;
					end
					ST_WDEV: begin
						if (pend_q == PEND_WRITE) begin
							bstat_d        = STAT_WRITING;
							res_d.do_start = 1'b1;
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = taddr_q;
							state_d        = ST_WAIT;
							resume_d       = ST_WREG;
						end
					end
					ST_WREG: begin
						if (bstat_q == STAT_WRITING) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = raddr_q;
							state_d        = ST_WAIT;
							resume_d       = ST_WDATA;
						end
					end
					ST_WDATA: begin
						if (bstat_q == STAT_WRITING) begin
							if (wcnt_q < tlen_q) begin
								// byte comes from the buffer read issued now
								mem_sel_d      = int'(wcnt_q) < BUF_DEPTH;
								res_d.tx_valid = 1'b1;
								wcnt_d         = wcnt_q + CNT_W'(1);
								state_d        = ST_WAIT;
								resume_d       = ST_WDATA;
							end else begin
								res_d.do_stop = 1'b1;
								bstat_d       = STAT_WDONE;
								pend_d        = PEND_NONE;
								wcnt_d        = '0;
								state_d       = ST_IDLE;
							end
						end
					end
					default: begin
						state_d = ST_IDLE;
						bstat_d = STAT_IDLE;
						pend_d  = PEND_NONE;
					end
				endcase
			end
			CMD_LOAD: begin
				// buffer write only, handled by the RAM port
			end
			default: begin
				if (pend_q == PEND_NONE) begin
					taddr_d = in_dev;
					raddr_d = in_reg;
					tlen_d  = in_cnt;
					pend_d  = (in_cmd == CMD_READ) ? PEND_READ : PEND_WRITE;
				end
			end
		endcase

		res_d.status = bstat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			resume_q <= ST_IDLE;
			pend_q   <= PEND_NONE;
			taddr_q  <= '0;
			raddr_q  <= '0;
			tlen_q   <= '0;
			rcnt_q   <= '0;
			wcnt_q   <= '0;
			last_q   <= 1'b0;
			bstat_q  <= STAT_IDLE;
		end else if (accept) begin
			state_q  <= state_d;
			resume_q <= resume_d;
			pend_q   <= pend_d;
			taddr_q  <= taddr_d;
			raddr_q  <= raddr_d;
			tlen_q   <= tlen_d;
			rcnt_q   <= rcnt_d;
			wcnt_q   <= wcnt_d;
			last_q   <= last_d;
			bstat_q  <= bstat_d;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv2) begin
				s1_valid_q <= 1'b0;
			end
			if (adv2) begin
				s2_valid_q <= 1'b1;
			end else if (m_tready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// middle stage with the buffer byte merged in
	always_comb begin
		res_merge = res_s1;
		if (mem_sel_s1) begin
			res_merge.tx_byte = buf_rdata;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res_d;
			mem_sel_s1 <= mem_sel_d;
		end
		if (adv2) begin
			res_s2 <= res_merge;
		end
	end

	assign m_tvalid = s2_valid_q;
	assign m_tdata  = {1'b0, res_s2.rd_byte, res_s2.rd_index, res_s2.rd_valid,
		res_s2.status, res_s2.clear_flag, res_s2.send_nack, res_s2.rx_prime,
		res_s2.tx_byte, res_s2.tx_valid, res_s2.do_stop, res_s2.do_restart,
		res_s2.do_start};

	// a transmit byte and a receive prime never share a beat
	`ASSERT_NOW(a_tx_rx_excl, s2_valid_q, !(res_s2.tx_valid && res_s2.rx_prime))
	// every byte sent or primed parks the sequencer on the done flag
	`ASSERT_NEXT(a_wait_after_byte,
		accept && (res_d.tx_valid || res_d.rx_prime), state_q == ST_WAIT)
	// with nothing pending the sequencer sits idle
	`ASSERT_NOW(a_idle_when_free, pend_q == PEND_NONE, state_q == ST_IDLE)
	// an occupied middle stage only takes a new beat while it drains
	`ASSERT_NOW(a_s1_no_overrun, accept && s1_valid_q, adv2)

endmodule
